// ----- design/sddc_pkg.sv -----
// ----------------------------------------------------------------------------
// sddc_pkg
// Shared constants, tables and control types for the serial day / date
// converter.
// ----------------------------------------------------------------------------
package sddc_pkg;

  // Calendar window
  localparam int BASE_YEAR  = 1900;
  localparam int YEAR_COUNT = 256;

  // Field widths
  localparam int SERIAL_W = 17;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YDAY_W   = 9;
  localparam int ERR_W    = 3;

  // Year table addressing
  localparam int IDX_W     = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1;
  localparam int TAB_DEPTH = 2 ** IDX_W;
  localparam int BIT_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  // Phase of BASE_YEAR in the leap cycles
  localparam int FY_MOD4   = BASE_YEAR % 4;
  localparam int FY_MOD100 = BASE_YEAR % 100;
  localparam int FY_MOD400 = BASE_YEAR % 400;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_YEAR_LOW  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_YEAR_HIGH = 3'd2;
  localparam logic [ERR_W-1:0] ERR_MONTH     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DAY       = 3'd4;

  // Request types
  localparam logic REQ_TO_DATE   = 1'b0;
  localparam logic REQ_TO_SERIAL = 1'b1;

  // Month numbers with special meaning
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef logic [SERIAL_W-1:0] start_tab_t [TAB_DEPTH];
  typedef logic [DAY_W-1:0]    month_len_t [16];
  typedef logic [YDAY_W-1:0]   month_start_t [16];

  // Month length by month number; non-months read 0
  localparam month_len_t MONTH_LEN = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // Days before the first of each month, common year
  localparam month_start_t MONTH_START = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
  };

  // Serial of 1 January for each table year; unused slots saturate
  function automatic start_tab_t build_start_tab();
    start_tab_t t;
    int acc;
    int r4;
    int r100;
    int r400;
    bit lp;
    acc  = 0;
    r4   = FY_MOD4;
    r100 = FY_MOD100;
    r400 = FY_MOD400;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      if (i < YEAR_COUNT) begin
        t[i] = SERIAL_W'(acc);
      end else begin
        t[i] = '1;
      end
      lp   = (r4 == 0) && ((r100 != 0) || (r400 == 0));
      acc  = acc + 365 + int'(lp);
      r4   = (r4 == 3) ? 0 : r4 + 1;
      r100 = (r100 == 99) ? 0 : r100 + 1;
      r400 = (r400 == 399) ? 0 : r400 + 1;
    end
    return t;
  endfunction

  // Leap flag for each table year
  function automatic logic [TAB_DEPTH-1:0] build_leap_tab();
    logic [TAB_DEPTH-1:0] t;
    int r4;
    int r100;
    int r400;
    r4   = FY_MOD4;
    r100 = FY_MOD100;
    r400 = FY_MOD400;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      t[i] = (r4 == 0) && ((r100 != 0) || (r400 == 0));
      r4   = (r4 == 3) ? 0 : r4 + 1;
      r100 = (r100 == 99) ? 0 : r100 + 1;
      r400 = (r400 == 399) ? 0 : r400 + 1;
    end
    return t;
  endfunction

  localparam start_tab_t           START_TAB    = build_start_tab();
  localparam logic [TAB_DEPTH-1:0] LEAP_TAB     = build_leap_tab();
  localparam logic [SERIAL_W-1:0]  SERIAL_LIMIT = START_TAB[YEAR_COUNT-1];

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic search_step;
    logic split;
    logic walk_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode;
    logic err_any;
    logic search_last;
    logic walk_done;
  } status_t;

endpackage

// ----- design/sddc_datapath.sv -----
// ----------------------------------------------------------------------------
// sddc_datapath
// Request registers, year table search, month walk and result registers.
// ----------------------------------------------------------------------------
module sddc_datapath (
  input  logic                            clk,
  input  sddc_pkg::cmd_t                  cmd,
  output sddc_pkg::status_t               status,
  input  logic                            req_type,
  input  logic [sddc_pkg::SERIAL_W-1:0]   serial_in,
  input  logic [sddc_pkg::YEAR_W-1:0]     year_in,
  input  logic [sddc_pkg::MONTH_W-1:0]    month_in,
  input  logic [sddc_pkg::DAY_W-1:0]      day_in,
  output logic [sddc_pkg::YEAR_W-1:0]     year_out,
  output logic [sddc_pkg::MONTH_W-1:0]    month_out,
  output logic [sddc_pkg::DAY_W-1:0]      day_out,
  output logic [sddc_pkg::SERIAL_W-1:0]   serial_out,
  output logic [sddc_pkg::YDAY_W-1:0]     yday_out,
  output logic                            leap_out,
  output logic                            valid_out,
  output logic [sddc_pkg::ERR_W-1:0]      error_code
);

  // Latched request
  logic                           mode;
  logic [sddc_pkg::SERIAL_W-1:0]  serial;
  logic [sddc_pkg::YEAR_W-1:0]    year;
  logic [sddc_pkg::MONTH_W-1:0]   month;
  logic [sddc_pkg::DAY_W-1:0]     day;

  // Search and walk state
  logic [sddc_pkg::IDX_W-1:0]     idx;
  logic [sddc_pkg::BIT_W-1:0]     bit_cnt;
  logic [sddc_pkg::YDAY_W-1:0]    rem;
  logic [sddc_pkg::YDAY_W-1:0]    yday;
  logic [sddc_pkg::MONTH_W-1:0]   m;
  logic                           leap;

  logic [sddc_pkg::YEAR_W-1:0]    yoff;
  logic [sddc_pkg::IDX_W-1:0]     yidx;
  logic                           leap1;
  logic [sddc_pkg::DAY_W-1:0]     dmax;
  logic [sddc_pkg::ERR_W-1:0]     err;
  logic [sddc_pkg::IDX_W-1:0]     cand;
  logic [sddc_pkg::YDAY_W-1:0]    len;
  logic [sddc_pkg::YDAY_W-1:0]    yd1;
  logic [sddc_pkg::SERIAL_W-1:0]  serial1;

  // Range checks on the latched request
  assign yoff  = year - sddc_pkg::YEAR_W'(sddc_pkg::BASE_YEAR);
  assign yidx  = yoff[sddc_pkg::IDX_W-1:0];
  assign leap1 = sddc_pkg::LEAP_TAB[yidx];
  assign dmax  = sddc_pkg::MONTH_LEN[month]
               + sddc_pkg::DAY_W'((month == sddc_pkg::MONTH_FEB) && leap1);

  always_comb begin
    priority if (mode == sddc_pkg::REQ_TO_DATE) begin
      err = (serial >= sddc_pkg::SERIAL_LIMIT) ? sddc_pkg::ERR_DAY : sddc_pkg::ERR_OK;
    end else if (year < sddc_pkg::YEAR_W'(sddc_pkg::BASE_YEAR)) begin
      err = sddc_pkg::ERR_YEAR_LOW;
    end else if ({1'b0, year} >=
                 (sddc_pkg::YEAR_W+1)'(sddc_pkg::BASE_YEAR + sddc_pkg::YEAR_COUNT)) begin
      err = sddc_pkg::ERR_YEAR_HIGH;
    end else if ((month < sddc_pkg::MONTH_JAN) || (month > sddc_pkg::MONTH_DEC)) begin
      err = sddc_pkg::ERR_MONTH;
    end else if ((day == '0) || (day > dmax)) begin
      err = sddc_pkg::ERR_DAY;
    end else begin
      err = sddc_pkg::ERR_OK;
    end
  end

  // Binary search candidate and month walk length
  assign cand = idx | (sddc_pkg::IDX_W'(1) << bit_cnt);
  assign len  = sddc_pkg::YDAY_W'(sddc_pkg::MONTH_LEN[m])
              + sddc_pkg::YDAY_W'((m == sddc_pkg::MONTH_FEB) && leap);

  // Date to serial
  assign yd1 = sddc_pkg::MONTH_START[month]
             + sddc_pkg::YDAY_W'((month > sddc_pkg::MONTH_FEB) && leap1)
             + sddc_pkg::YDAY_W'(day) - sddc_pkg::YDAY_W'(1);
  assign serial1 = sddc_pkg::START_TAB[yidx] + sddc_pkg::SERIAL_W'(yd1);

  assign status.mode        = mode;
  assign status.err_any     = (err != sddc_pkg::ERR_OK);
  assign status.search_last = (bit_cnt == '0);
  assign status.walk_done   = (m == sddc_pkg::MONTH_DEC) || (rem < len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= req_type;
      serial  <= serial_in;
      year    <= year_in;
      month   <= month_in;
      day     <= day_in;
      idx     <= '0;
      bit_cnt <= sddc_pkg::BIT_W'(sddc_pkg::IDX_W - 1);
    end
    if (cmd.search_step) begin
      if (sddc_pkg::START_TAB[cand] <= serial) begin
        idx <= cand;
      end
      bit_cnt <= bit_cnt - sddc_pkg::BIT_W'(1);
    end
    if (cmd.split) begin
      rem  <= sddc_pkg::YDAY_W'(serial - sddc_pkg::START_TAB[idx]);
      yday <= sddc_pkg::YDAY_W'(serial - sddc_pkg::START_TAB[idx]);
      leap <= sddc_pkg::LEAP_TAB[idx];
      m    <= sddc_pkg::MONTH_JAN;
    end
    if (cmd.walk_step) begin
      rem <= rem - len;
      m   <= m + sddc_pkg::MONTH_W'(1);
    end
    if (cmd.out_load) begin
      error_code <= err;
      priority if (err != sddc_pkg::ERR_OK) begin
        year_out   <= '0;
        month_out  <= '0;
        day_out    <= '0;
        serial_out <= '0;
        yday_out   <= '0;
        leap_out   <= 1'b0;
        valid_out  <= 1'b0;
      end else if (mode == sddc_pkg::REQ_TO_DATE) begin
        year_out   <= sddc_pkg::YEAR_W'(sddc_pkg::BASE_YEAR) + sddc_pkg::YEAR_W'(idx);
        month_out  <= m;
        day_out    <= sddc_pkg::DAY_W'(rem) + sddc_pkg::DAY_W'(1);
        serial_out <= serial;
        yday_out   <= yday;
        leap_out   <= leap;
        valid_out  <= 1'b1;
      end else begin
        year_out   <= year;
        month_out  <= month;
        day_out    <= day;
        serial_out <= serial1;
        yday_out   <= yd1;
        leap_out   <= leap1;
        valid_out  <= 1'b1;
      end
    end
  end

endmodule

// ----- design/sddc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sddc_ctrl
// Sequencer for check, year search, month walk and result handoff.
// ----------------------------------------------------------------------------
module sddc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sddc_pkg::status_t status,
  output sddc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.err_any || (status.mode == sddc_pkg::REQ_TO_SERIAL)) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_last) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (status.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/serial_day_date_converter_top.sv -----
// ----------------------------------------------------------------------------
// serial_day_date_converter_top
// Gregorian serial day number <-> civil date converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request transaction:
//   req_type 0 converts serial_in to year/month/day, req_type 1 converts
//   year_in/month_in/day_in to a serial and day of year. Serials count days
//   from 1 January of the first table year.
//   Output channel (out_valid/out_ready) returns exactly one result
//   transaction per request, with leap flag, valid_out and error_code.
//   Failed range checks give valid_out low and all date fields zero.
// Timing:
//   Date to serial, or any error: the check state leads straight to the
//   finish state. Serial to date: check, IDX_W (8) year table search
//   steps, a split, up to 11 month walk steps, then finish. The year
//   search and the month walk, one step per cycle, set its duration. One
//   request is in flight at a time; in_ready is high only while idle, so
//   a new request is accepted only after the previous one has finished.
// Stall:
//   The result sits in an output register; a new request is accepted while
//   it waits. A finished request holds until the output slot frees up.
// Reset:
//   rst (synchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module serial_day_date_converter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [sddc_pkg::SERIAL_W-1:0]   serial_in,
  input  logic [sddc_pkg::YEAR_W-1:0]     year_in,
  input  logic [sddc_pkg::MONTH_W-1:0]    month_in,
  input  logic [sddc_pkg::DAY_W-1:0]      day_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sddc_pkg::YEAR_W-1:0]     year_out,
  output logic [sddc_pkg::MONTH_W-1:0]    month_out,
  output logic [sddc_pkg::DAY_W-1:0]      day_out,
  output logic [sddc_pkg::SERIAL_W-1:0]   serial_out,
  output logic [sddc_pkg::YDAY_W-1:0]     yday_out,
  output logic                            leap_out,
  output logic                            valid_out,
  output logic [sddc_pkg::ERR_W-1:0]      error_code
);

  sddc_pkg::cmd_t    cmd;
  sddc_pkg::status_t status;

  // Sequencer: owns handshakes and step commands
  sddc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: table search, month walk, result registers
  sddc_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req_type),
    .serial_in  (serial_in),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .serial_out (serial_out),
    .yday_out   (yday_out),
    .leap_out   (leap_out),
    .valid_out  (valid_out),
    .error_code (error_code)
  );

endmodule
